>>> hdl/pd2_pkg.sv
// Package: types, constants and the arctangent table for the pose deviation block.
`timescale 1ns / 1ps
package pd2_pkg;

    // Number of CORDIC iterations for both the yaw and the rotation units.
    localparam int ANGLE_ITERATIONS = 16;
    localparam int N_ITER = (ANGLE_ITERATIONS > 24) ? 24 : ANGLE_ITERATIONS;

    // Width of the CORDIC vector datapath for the yaw unit (Q4.28 plus growth).
    localparam int YW = 35;
    // Width of the rotation datapath: 33-bit offset times 16, plus growth.
    localparam int RW = 40;
    // Inverse CORDIC gain in Q24.
    localparam logic signed [24:0] KINV_Q24 = 25'sd10188014;

    typedef struct packed {
        logic signed [31:0] base_x;
        logic signed [31:0] base_y;
        logic signed [15:0] base_qx;
        logic signed [15:0] base_qy;
        logic signed [15:0] base_qz;
        logic signed [15:0] base_qw;
        logic signed [31:0] target_x;
        logic signed [31:0] target_y;
        logic signed [15:0] target_qx;
        logic signed [15:0] target_qy;
        logic signed [15:0] target_qz;
        logic signed [15:0] target_qw;
    } t_in_word;

    typedef struct packed {
        logic signed [31:0] lateral_offset;
        logic signed [31:0] longitudinal_offset;
        logic signed [15:0] heading_error;
        logic               distance_clipped;
    } t_out_word;

    // Arctangent of 2^-i as a 32-bit binary angle.
    function automatic logic [31:0] atan_tab(input logic [4:0] idx);
        logic [31:0] v;
        begin
            unique case (idx)
                5'd0:  v = 32'd536870912;
                5'd1:  v = 32'd316933406;
                5'd2:  v = 32'd167458907;
                5'd3:  v = 32'd85004756;
                5'd4:  v = 32'd42667331;
                5'd5:  v = 32'd21354465;
                5'd6:  v = 32'd10679838;
                5'd7:  v = 32'd5340245;
                5'd8:  v = 32'd2670163;
                5'd9:  v = 32'd1335087;
                5'd10: v = 32'd667544;
                5'd11: v = 32'd333772;
                5'd12: v = 32'd166886;
                5'd13: v = 32'd83443;
                5'd14: v = 32'd41722;
                5'd15: v = 32'd20861;
                5'd16: v = 32'd10430;
                5'd17: v = 32'd5215;
                5'd18: v = 32'd2608;
                5'd19: v = 32'd1304;
                5'd20: v = 32'd652;
                5'd21: v = 32'd326;
                5'd22: v = 32'd163;
                5'd23: v = 32'd81;
                default: v = 32'd0;
            endcase
            return v;
        end
    endfunction

endpackage

>>> hdl/pd2_yaw.sv
// Pipelined quaternion-to-yaw unit: products, operand fold, then one vectoring CORDIC stage per iteration.
`timescale 1ns / 1ps
module pd2_yaw (
    input  logic                i_clk,
    input  logic                i_en,
    input  logic signed [15:0]  i_qx,
    input  logic signed [15:0]  i_qy,
    input  logic signed [15:0]  i_qz,
    input  logic signed [15:0]  i_qw,
    output logic [31:0]         o_yaw
);

    localparam int N = pd2_pkg::N_ITER;
    localparam int W = pd2_pkg::YW;

    // Stage one: the four quaternion products.
    logic signed [31:0] r_wz, r_xy, r_yy, r_zz;
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_wz <= 32'(i_qw) * 32'(i_qz);
            r_xy <= 32'(i_qx) * 32'(i_qy);
            r_yy <= 32'(i_qy) * 32'(i_qy);
            r_zz <= 32'(i_qz) * 32'(i_qz);
        end
    end

    // Stage two: the atan2 operands, folded into the right half plane.
    logic signed [W-1:0] n_num, n_den;
    logic signed [W-1:0] r_x [0:N];
    logic signed [W-1:0] r_y [0:N];
    logic [31:0]         r_z [0:N];
    logic                r_zero [0:N];
    always_comb begin
        n_num = W'(2) * (W'(r_wz) + W'(r_xy));
        n_den = (W'(1) <<< 28) - W'(2) * (W'(r_yy) + W'(r_zz));
    end
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_zero[0] <= (n_num == '0) && (n_den == '0);
            if (n_den < 0) begin
                r_x[0] <= -n_den;
                r_y[0] <= -n_num;
                r_z[0] <= 32'h8000_0000;
            end else begin
                r_x[0] <= n_den;
                r_y[0] <= n_num;
                r_z[0] <= '0;
            end
        end
    end

    // One registered vectoring micro-rotation per stage.
    for (genvar i = 0; i < N; i++) begin : g_iter
        logic signed [W-1:0] xs, ys;
        assign xs = r_x[i] >>> i;
        assign ys = r_y[i] >>> i;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_zero[i+1] <= r_zero[i];
                if (r_y[i] > 0) begin
                    r_x[i+1] <= r_x[i] + ys;
                    r_y[i+1] <= r_y[i] - xs;
                    r_z[i+1] <= r_z[i] + pd2_pkg::atan_tab(5'(i));
                end else begin
                    r_x[i+1] <= r_x[i] - ys;
                    r_y[i+1] <= r_y[i] + xs;
                    r_z[i+1] <= r_z[i] - pd2_pkg::atan_tab(5'(i));
                end
            end
        end
    end

    // A degenerate quaternion gives a zero yaw.
    assign o_yaw = r_zero[N] ? 32'd0 : r_z[N];

endmodule

>>> hdl/pose_deviation_2d.sv
// Top level: planar pose deviation pipeline with valid/ready channels.
`timescale 1ns / 1ps
// Usage: one input word carries a base and a target pose (Q16.16 position,
// Q2.14 quaternion). One output word per input word gives the lateral and
// longitudinal offset of the target in the base frame, the wrapped heading
// error and a saturation flag.
// Both channels use valid/ready. The pipeline accepts one word per cycle
// while the output side keeps up. From input accept to output valid, a word
// passes the two CORDIC chains in series, yaw extraction then vector
// rotation, then the gain multiply pipeline and the output register.
// When the receiver stalls, the whole pipeline holds in place; a word in
// the output register waits, and o_ready falls only while the output word
// is held and the pipeline cannot advance. A skid-free global enable is
// used: the pipeline advances when the output register is empty or taken.
// Reset clears all valid bits; payload registers are not reset.
module pose_deviation_2d (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  pd2_pkg::t_in_word  i_data,
    output logic               o_valid,
    input  logic               i_ready,
    output pd2_pkg::t_out_word o_data
);

    localparam int N = pd2_pkg::N_ITER;
    localparam int W = pd2_pkg::RW;
    // Stages before the rotation chain: yaw unit takes N + 2.
    localparam int YL = N + 2;
    // Total valid pipe length up to the output register.
    localparam int L = YL + N + 5;

    logic en;
    logic r_v [0:L-1];
    assign en = !o_valid || i_ready;
    assign o_ready = en;

    // Valid bits travel with the data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < L; k++) r_v[k] <= 1'b0;
        end else if (en) begin
            r_v[0] <= i_valid;
            for (int k = 1; k < L; k++) r_v[k] <= r_v[k-1];
        end
    end
    assign o_valid = r_v[L-1];

    // Yaw extraction for both poses.
    logic [31:0] byaw, tyaw;
    pd2_yaw u_byaw (
        .i_clk(i_clk), .i_en(en),
        .i_qx(i_data.base_qx), .i_qy(i_data.base_qy),
        .i_qz(i_data.base_qz), .i_qw(i_data.base_qw), .o_yaw(byaw)
    );
    pd2_yaw u_tyaw (
        .i_clk(i_clk), .i_en(en),
        .i_qx(i_data.target_qx), .i_qy(i_data.target_qy),
        .i_qz(i_data.target_qz), .i_qw(i_data.target_qw), .o_yaw(tyaw)
    );

    // Position offsets delayed alongside the yaw unit.
    logic signed [32:0] r_dx [0:YL-1];
    logic signed [32:0] r_dy [0:YL-1];
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dx[0] <= 33'(i_data.target_x) - 33'(i_data.base_x);
            r_dy[0] <= 33'(i_data.target_y) - 33'(i_data.base_y);
            for (int k = 1; k < YL; k++) begin
                r_dx[k] <= r_dx[k-1];
                r_dy[k] <= r_dy[k-1];
            end
        end
    end

    // Rotation setup: fold the base yaw into [-pi/2, pi/2), scale by 16.
    logic signed [W-1:0] r_x [0:N];
    logic signed [W-1:0] r_y [0:N];
    logic signed [32:0]  r_z [0:N];
    logic [31:0]         r_d [0:N];
    logic signed [32:0]  theta, n_theta;
    logic                flip;
    logic signed [W-1:0] sx, sy;
    always_comb begin
        theta = 33'(signed'(byaw));
        flip  = (theta >= (33'sd1 <<< 30)) || (theta < -(33'sd1 <<< 30));
        if (theta >= (33'sd1 <<< 30)) n_theta = theta - (33'sd1 <<< 31);
        else if (flip) n_theta = theta + (33'sd1 <<< 31);
        else n_theta = theta;
        sx = W'(r_dx[YL-1]) <<< 4;
        sy = W'(r_dy[YL-1]) <<< 4;
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_x[0] <= flip ? -sx : sx;
            r_y[0] <= flip ? -sy : sy;
            r_z[0] <= -n_theta;
            r_d[0] <= tyaw - byaw + 32'h0000_8000;
        end
    end

    // Rotation CORDIC, one micro-rotation per stage.
    for (genvar i = 0; i < N; i++) begin : g_rot
        logic signed [W-1:0] xs, ys;
        logic signed [32:0]  at;
        assign xs = r_x[i] >>> i;
        assign ys = r_y[i] >>> i;
        assign at = 33'(pd2_pkg::atan_tab(5'(i)));
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_d[i+1] <= r_d[i];
                if (r_z[i] >= 0) begin
                    r_x[i+1] <= r_x[i] - ys;
                    r_y[i+1] <= r_y[i] + xs;
                    r_z[i+1] <= r_z[i] - at;
                end else begin
                    r_x[i+1] <= r_x[i] + ys;
                    r_y[i+1] <= r_y[i] - xs;
                    r_z[i+1] <= r_z[i] + at;
                end
            end
        end
    end

    // Gain correction: 40 x 25 split into low and high partial products.
    logic signed [W-1:0]  r_xh, r_yh;
    logic        [19:0]   r_xl, r_yl;
    logic [31:0]          r_d1, r_d2, r_d3;
    logic signed [45:0]   r_pxh, r_pyh;
    logic signed [45:0]   r_pxl, r_pyl;
    logic signed [65:0]   r_px, r_py;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_xh <= r_x[N] >>> 20;
            r_yh <= r_y[N] >>> 20;
            r_xl <= r_x[N][19:0];
            r_yl <= r_y[N][19:0];
            r_d1 <= r_d[N];
            r_pxh <= 46'(r_xh) * 46'(pd2_pkg::KINV_Q24);
            r_pyh <= 46'(r_yh) * 46'(pd2_pkg::KINV_Q24);
            r_pxl <= 46'(signed'({1'b0, r_xl})) * 46'(pd2_pkg::KINV_Q24);
            r_pyl <= 46'(signed'({1'b0, r_yl})) * 46'(pd2_pkg::KINV_Q24);
            r_d2 <= r_d1;
            r_px <= (66'(r_pxh) <<< 20) + 66'(r_pxl) + (66'sd1 <<< 27);
            r_py <= (66'(r_pyh) <<< 20) + 66'(r_pyl) + (66'sd1 <<< 27);
            r_d3 <= r_d2;
        end
    end

    // Round, saturate and register the output word.
    logic signed [37:0] lon_r, lat_r;
    logic               lon_hi, lon_lo, lat_hi, lat_lo;
    pd2_pkg::t_out_word n_out, r_out;
    always_comb begin
        lon_r  = 38'(r_px >>> 28);
        lat_r  = 38'(r_py >>> 28);
        lon_hi = lon_r > 38'sh0_7FFF_FFFF;
        lon_lo = lon_r < -38'sh0_8000_0000;
        lat_hi = lat_r > 38'sh0_7FFF_FFFF;
        lat_lo = lat_r < -38'sh0_8000_0000;
        n_out.longitudinal_offset = lon_hi ? 32'sh7FFF_FFFF :
                                    lon_lo ? 32'sh8000_0000 : lon_r[31:0];
        n_out.lateral_offset      = lat_hi ? 32'sh7FFF_FFFF :
                                    lat_lo ? 32'sh8000_0000 : lat_r[31:0];
        n_out.heading_error       = r_d3[31:16];
        n_out.distance_clipped    = lon_hi | lon_lo | lat_hi | lat_lo;
    end
    always_ff @(posedge i_clk) begin
        if (en) r_out <= n_out;
    end
    assign o_data = r_out;

`ifndef SYNTHESIS
    // A stalled output word keeps its value.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> $stable(o_data))
        else $error("output word changed while stalled");
    // A stalled output word stays valid.
    a_keep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid)
        else $error("output valid dropped while stalled");
    // Ready is high whenever the output register is empty.
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready)
        else $error("input stalled with empty output");
`endif

endmodule

>>> tb/sv/pose_deviation_2d_tb.sv
// Testbench for the planar pose deviation block: random and directed pose pairs, scoreboard check.
`timescale 1ns / 1ps
module pose_deviation_2d_tb;

    localparam int LATENCY     = 2 * pd2_pkg::N_ITER + 7;
    localparam int WATCHDOG    = 20000;
    localparam int N_RANDOM    = 1400;

    logic                i_clk;
    logic                i_rst_n;
    logic                in_valid;
    logic                in_ready;
    pd2_pkg::t_in_word   in_word;
    logic                out_valid;
    logic                out_ready;
    pd2_pkg::t_out_word  out_word;

    pd2_pkg::t_in_word   pending_words[$];
    pd2_pkg::t_out_word  expected_deviations[$];
    int         send_idle_pct;
    int         recv_stall_pct;
    bit         hold_sender;
    bit         stim_done;
    int         mismatch_count;
    int         quiet_cycles;

    pose_deviation_2d u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (in_valid),
        .o_ready (in_ready),
        .i_data  (in_word),
        .o_valid (out_valid),
        .i_ready (out_ready),
        .o_data  (out_word)
    );

    // Clock generation.
    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    // Floor shift of a signed value.
    function automatic longint floor_shift(longint v, int s);
        return v >>> s;
    endfunction

    // Arctangent step table, 2^32 equals a full turn.
    function automatic logic [31:0] atan_angle(int i);
        logic [31:0] steps [24];
        steps = '{536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
                  10679838, 5340245, 2670163, 1335087, 667544, 333772,
                  166886, 83443, 41722, 20861, 10430, 5215,
                  2608, 1304, 652, 326, 163, 81};
        return steps[i];
    endfunction

    // Yaw of a Q2.14 quaternion as a 32-bit binary angle, by vectoring CORDIC.
    function automatic logic [31:0] quat_heading(logic signed [15:0] qx, logic signed [15:0] qy,
                                                 logic signed [15:0] qz, logic signed [15:0] qw);
        longint num;
        longint den;
        longint vx;
        longint vy;
        longint sx;
        longint sy;
        logic [31:0] ang;
        num = 2 * (longint'(qw) * longint'(qz) + longint'(qx) * longint'(qy));
        den = (longint'(1) <<< 28) - 2 * (longint'(qy) * longint'(qy) + longint'(qz) * longint'(qz));
        if (num == 0 && den == 0) begin
            return 32'd0;
        end
        vx  = den;
        vy  = num;
        ang = 32'd0;
        // Fold a negative real part onto the right half plane.
        if (den < 0) begin
            vx  = -den;
            vy  = -num;
            ang = 32'h8000_0000;
        end
        for (int i = 0; i < pd2_pkg::N_ITER; i++) begin
            sx = floor_shift(vx, i);
            sy = floor_shift(vy, i);
            if (vy > 0) begin
                vx  = vx + sy;
                vy  = vy - sx;
                ang = ang + atan_angle(i);
            end else begin
                vx  = vx - sy;
                vy  = vy + sx;
                ang = ang - atan_angle(i);
            end
        end
        return ang;
    endfunction

    // Gain correction, rounding and saturation of one rotated coordinate.
    function automatic logic signed [31:0] scale_distance(longint v, ref bit clipped);
        longint r;
        r = floor_shift(v * 64'sd10188014 + (longint'(1) <<< 27), 28);
        if (r > 64'sd2147483647) begin
            clipped = 1'b1;
            return 32'sh7fff_ffff;
        end
        if (r < -64'sd2147483648) begin
            clipped = 1'b1;
            return 32'sh8000_0000;
        end
        return r[31:0];
    endfunction

    // Expected deviation of the target pose as seen from the base pose.
    function automatic pd2_pkg::t_out_word predict_deviation(pd2_pkg::t_in_word w);
        pd2_pkg::t_out_word res;
        logic [31:0] from_heading;
        logic [31:0] to_heading;
        logic [31:0] diff;
        longint px;
        longint py;
        longint sx;
        longint sy;
        longint theta;
        longint zr;
        bit clipped;
        from_heading = quat_heading(w.base_qx, w.base_qy, w.base_qz, w.base_qw);
        to_heading   = quat_heading(w.target_qx, w.target_qy, w.target_qz, w.target_qw);
        px    = (longint'(w.target_x) - longint'(w.base_x)) * 16;
        py    = (longint'(w.target_y) - longint'(w.base_y)) * 16;
        theta = longint'(signed'(from_heading));
        // Bring the rotation angle into the CORDIC range by a half turn.
        if (theta >= (longint'(1) <<< 30)) begin
            theta = theta - (longint'(1) <<< 31);
            px = -px;
            py = -py;
        end else if (theta < -(longint'(1) <<< 30)) begin
            theta = theta + (longint'(1) <<< 31);
            px = -px;
            py = -py;
        end
        zr = -theta;
        for (int i = 0; i < pd2_pkg::N_ITER; i++) begin
            sx = floor_shift(px, i);
            sy = floor_shift(py, i);
            if (zr >= 0) begin
                px = px - sy;
                py = py + sx;
                zr = zr - longint'(atan_angle(i));
            end else begin
                px = px + sy;
                py = py - sx;
                zr = zr + longint'(atan_angle(i));
            end
        end
        clipped = 1'b0;
        res.longitudinal_offset = scale_distance(px, clipped);
        res.lateral_offset      = scale_distance(py, clipped);
        diff = to_heading - from_heading + 32'h0000_8000;
        res.heading_error    = diff[31:16];
        res.distance_clipped = clipped;
        return res;
    endfunction

    // Quaternion for a given binary yaw angle, roughly unit length.
    function automatic void yaw_quat(int ang16, output logic signed [15:0] qz,
                                     output logic signed [15:0] qw);
        real half;
        half = (ang16 * 3.14159265358979 / 32768.0) / 2.0;
        qz = 16'($rtoi(16384.0 * $sin(half)));
        qw = 16'($rtoi(16384.0 * $cos(half)));
    endfunction

    function automatic pd2_pkg::t_in_word random_word();
        pd2_pkg::t_in_word w;
        int mode;
        w = {$urandom, $urandom, $urandom, $urandom,
             $urandom, $urandom, $urandom, $urandom};
        mode = $urandom_range(0, 9);
        // Mostly realistic poses: nearby positions, unit yaw-only quaternions.
        if (mode < 7) begin
            w.target_x = w.base_x + $signed($urandom_range(0, 32'h00ff_ffff)) - 32'sh0080_0000;
            w.target_y = w.base_y + $signed($urandom_range(0, 32'h00ff_ffff)) - 32'sh0080_0000;
            w.base_qx = '0;
            w.base_qy = '0;
            w.target_qx = '0;
            w.target_qy = '0;
            yaw_quat($urandom_range(0, 65535) - 32768, w.base_qz, w.base_qw);
            yaw_quat($urandom_range(0, 65535) - 32768, w.target_qz, w.target_qw);
            if (mode == 0) begin
                w.base_qx = 16'($urandom_range(0, 2000) - 1000);
                w.target_qy = 16'($urandom_range(0, 2000) - 1000);
            end
        end
        return w;
    endfunction

    function automatic pd2_pkg::t_in_word directed_word(int k);
        pd2_pkg::t_in_word w;
        w = '0;
        w.base_qw = 16'sd16384;
        w.target_qw = 16'sd16384;
        case (k)
            0: w.target_x = 32'sd65536;
            1: begin
                w.base_x = 32'sh8000_0000;
                w.target_x = 32'sh7fff_ffff;
            end
            2: begin
                w.base_y = 32'sh7fff_ffff;
                w.target_y = 32'sh8000_0000;
            end
            3: begin
                w.base_qw = 0;
                w.target_qw = 0;
                w.target_x = 32'sd100000;
            end
            4: begin
                w.base_qz = 16'sd16384;
                w.base_qw = 0;
                w.target_y = 32'sd65536;
            end
            5: begin
                w.base_qz = -16'sd16384;
                w.base_qw = 0;
                w.target_x = -32'sd70000;
            end
            6: begin
                w.base_qz = 16'sd11585;
                w.base_qw = 16'sd11585;
                w.target_qz = -16'sd11585;
                w.target_qw = 16'sd11585;
                w.target_x = 32'sd300000;
            end
            7: begin
                w.base_qx = 16'sh7fff;
                w.base_qy = 16'sh8000;
                w.base_qz = 16'sh7fff;
                w.base_qw = 16'sh8000;
                w.target_qx = 16'sh8000;
                w.target_qy = 16'sh8000;
                w.target_qz = 16'sh8000;
                w.target_qw = 16'sh8000;
                w.target_x = 32'sh7fff_ffff;
                w.target_y = 32'sh7fff_ffff;
            end
            8: begin
                w.base_qz = 16'sd32767;
                w.base_qw = 16'sd1;
                w.target_qz = 16'sh8000;
                w.target_qw = 16'sd1;
            end
            9: begin
                w.base_qz = 16'sd20000;
                w.base_qw = -16'sd9000;
                w.base_x = 32'sh7fff_ffff;
                w.base_y = 32'sh7fff_ffff;
                w.target_x = 32'sh8000_0000;
                w.target_y = 32'sh8000_0000;
            end
            default: w = {32'hffff_ffff, 32'hffff_ffff, 64'hffff_ffff_ffff_ffff,
                          32'h0, 32'h0, 64'h0};
        endcase
        return w;
    endfunction

    // Stimulus and phase control.
    initial begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_sender    = 1'b0;
        stim_done      = 1'b0;
        i_rst_n        = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        for (int k = 0; k <= 10; k++) begin
            pending_words.push_back(directed_word(k));
        end
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 56; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 56; end
                default: begin send_idle_pct = 24; recv_stall_pct = 24; end
            endcase
            for (int n = 0; n < N_RANDOM / 4; n++) begin
                pending_words.push_back(random_word());
            end
            while (pending_words.size() != 0 || in_valid) @(posedge i_clk);
            // Let the pipeline drain completely before the next phase.
            hold_sender = 1'b1;
            while (expected_deviations.size() != 0) @(posedge i_clk);
            hold_sender = 1'b0;
        end
        repeat (LATENCY + 5) @(posedge i_clk);
        stim_done = 1'b1;
    end

    // Driver: presents queued words, holding each until accepted.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
            in_word  <= '0;
        end else if (!in_valid || in_ready) begin
            if (in_valid) begin
                expected_deviations.push_back(predict_deviation(in_word));
            end
            if (pending_words.size() != 0 && !hold_sender &&
                $urandom_range(1, 100) > send_idle_pct) begin
                in_word  <= pending_words.pop_front();
                in_valid <= 1'b1;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Monitor: random stalls on the output side and result checking.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (out_valid && out_ready) begin
                if (expected_deviations.size() == 0) begin
                    $error("unexpected output word %h", out_word);
                    mismatch_count++;
                end else begin
                    pd2_pkg::t_out_word exp_w;
                    exp_w = expected_deviations.pop_front();
                    if (out_word.lateral_offset !== exp_w.lateral_offset) begin
                        $error("lateral_offset: expected %0d, got %0d",
                               exp_w.lateral_offset, out_word.lateral_offset);
                        mismatch_count++;
                    end
                    if (out_word.longitudinal_offset !== exp_w.longitudinal_offset) begin
                        $error("longitudinal_offset: expected %0d, got %0d",
                               exp_w.longitudinal_offset, out_word.longitudinal_offset);
                        mismatch_count++;
                    end
                    if (out_word.heading_error !== exp_w.heading_error) begin
                        $error("heading_error: expected %0d, got %0d",
                               exp_w.heading_error, out_word.heading_error);
                        mismatch_count++;
                    end
                    if (out_word.distance_clipped !== exp_w.distance_clipped) begin
                        $error("distance_clipped: expected %0b, got %0b",
                               exp_w.distance_clipped, out_word.distance_clipped);
                        mismatch_count++;
                    end
                end
            end
            out_ready <= ($urandom_range(1, 100) > recv_stall_pct);
        end
    end

    // Watchdog on handshake progress, and the final verdict.
    initial begin
        mismatch_count = 0;
        quiet_cycles   = 0;
        forever begin
            @(posedge i_clk);
            if (stim_done) begin
                if (mismatch_count == 0 && expected_deviations.size() == 0) begin
                    $display("Simulation PASSED");
                end else begin
                    if (expected_deviations.size() != 0) begin
                        $error("%0d results never arrived", expected_deviations.size());
                    end
                    $display("Simulation FAILED");
                end
                $finish;
            end else if ((in_valid && in_ready) || (out_valid && out_ready)) begin
                quiet_cycles = 0;
            end else if (quiet_cycles >= WATCHDOG) begin
                $display("Simulation FAILED");
                $finish;
            end else begin
                quiet_cycles++;
            end
        end
    end

endmodule
